// ===== hw/rtl/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
// No dependencies; every other file in this block imports this package.
package spq_pkg;

    localparam int DEPTH  = 8;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int FILL_W = 4;
    localparam int WORD_W = 32;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic [CNT_W-1:0] count_t;
    typedef logic [FILL_W-1:0] fill_t;

    typedef enum logic [1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_DEQUEUED = 2'd2,
        ST_EMPTY    = 2'd3
    } status_t;

    typedef enum logic {
        MODE_ENQ = 1'b0,
        MODE_DEQ = 1'b1
    } mode_t;

    typedef struct packed {
        word_t value;
        word_t prio;
    } entry_t;

    // Per-cell control from the top level.
    typedef struct packed {
        logic do_enq;
        logic do_deq;
        logic occ;
        logic left_occ;
    } cell_ctrl_t;

endpackage

// ===== hw/rtl/spq_cell.sv =====
// One storage cell of the sorted priority queue chain.
// Depends on spq_pkg for the entry and control types.
module spq_cell (
    input  logic               clk,
    input  spq_pkg::cell_ctrl_t ctrl,
    input  spq_pkg::entry_t    new_entry,
    input  spq_pkg::entry_t    left_entry,
    input  spq_pkg::entry_t    right_entry,
    input  logic               left_gt,
    output spq_pkg::entry_t    entry,
    output logic               gt
);
    import spq_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    logic   ins_load;

    // A stored entry with a larger priority number moves back to make room.
    assign gt = ctrl.occ && (entry_reg.prio > new_entry.prio);

    // The cell loads on insert when it must shift or when it is the first free one.
    assign ins_load = (ctrl.occ && gt) || (!ctrl.occ && ctrl.left_occ);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.do_enq && ins_load)
        begin
            entry_next = left_gt ? left_entry : new_entry;
        end
        else if (ctrl.do_deq)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// ===== hw/rtl/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: chain of cells, count and result register.
// Depends on spq_pkg and spq_cell.
//
// Bounded priority queue of spq_pkg::DEPTH entries, kept sorted by signed priority
// number with the smallest at the head; equal priorities leave in arrival order.
// mode 0 inserts item_value/item_priority (status 1 if full), mode 1 removes the head
// (status 3 if empty). Each item gives exactly one result, which carries the count
// after the operation, and head_value/head_priority only on a successful dequeue.
// Every cell compares and shifts in parallel, and the result of an item appears in the
// output register on the next cycle. The block takes one item per cycle as long as
// results are taken; the single output register holds off new items only while an
// untaken result waits.
module sorted_priority_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                mode,
    input  spq_pkg::word_t      item_value,
    input  spq_pkg::word_t      item_priority,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          status,
    output spq_pkg::word_t      head_value,
    output spq_pkg::word_t      head_priority,
    output spq_pkg::fill_t      fill_count
);
    import spq_pkg::*;

    count_t  count_reg, count_next;
    logic    out_valid_reg, out_valid_next;
    status_t status_reg, status_next;
    word_t   head_value_reg, head_value_next;
    word_t   head_priority_reg, head_priority_next;
    fill_t   fill_reg, fill_next;

    logic    accept;
    logic    is_full;
    logic    is_empty;
    logic    do_enq;
    logic    do_deq;
    entry_t  new_entry;
    entry_t  cell_entry [DEPTH];
    logic    cell_gt    [DEPTH];
    logic    cell_occ   [DEPTH];

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign is_full   = (count_reg == CNT_W'(DEPTH));
    assign is_empty  = (count_reg == '0);
    assign do_enq    = accept && (mode == MODE_ENQ) && !is_full;
    assign do_deq    = accept && (mode == MODE_DEQ) && !is_empty;
    assign new_entry = '{value: item_value, prio: item_priority};

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            cell_ctrl_t ctrl;
            entry_t     left_e;
            entry_t     right_e;
            logic       left_g;

            assign cell_occ[i] = (count_reg > CNT_W'(i));

            if (i == 0)
            begin : g_first
                assign left_e = new_entry;
                assign left_g = 1'b0;
                assign ctrl.left_occ = 1'b1;
            end
            else
            begin : g_inner
                assign left_e = cell_entry[i-1];
                assign left_g = cell_gt[i-1];
                assign ctrl.left_occ = cell_occ[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_last
                assign right_e = cell_entry[i];
            end
            else
            begin : g_mid
                assign right_e = cell_entry[i+1];
            end

            assign ctrl.do_enq = do_enq;
            assign ctrl.do_deq = do_deq;
            assign ctrl.occ    = cell_occ[i];

            spq_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .new_entry   (new_entry),
                .left_entry  (left_e),
                .right_entry (right_e),
                .left_gt     (left_g),
                .entry       (cell_entry[i]),
                .gt          (cell_gt[i])
            );
        end
    endgenerate

    always_comb
    begin
        count_next = count_reg;
        if (do_enq)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_deq)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_comb
    begin
        out_valid_next     = out_valid_reg;
        status_next        = status_reg;
        head_value_next    = head_value_reg;
        head_priority_next = head_priority_reg;
        fill_next          = fill_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (accept)
        begin
            out_valid_next     = 1'b1;
            head_value_next    = '0;
            head_priority_next = '0;
            fill_next          = FILL_W'(count_next);
            if (mode == MODE_ENQ)
            begin
                status_next = is_full ? ST_FULL : ST_INSERTED;
            end
            else if (is_empty)
            begin
                status_next = ST_EMPTY;
            end
            else
            begin
                status_next        = ST_DEQUEUED;
                head_value_next    = cell_entry[0].value;
                head_priority_next = cell_entry[0].prio;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg        <= status_next;
        head_value_reg    <= head_value_next;
        head_priority_reg <= head_priority_next;
        fill_reg          <= fill_next;
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign head_value    = head_value_reg;
    assign head_priority = head_priority_reg;
    assign fill_count    = fill_reg;

endmodule
